// ----- hdl/yuyvp_pkg.sv -----
// Shared constants, register codes and a helper function for the YUYV packed-to-planar splitter.
package yuyvp_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;

  localparam int WORD_W     = 32;
  localparam int BYTE_W     = 8;
  localparam int LUMA_IDX_W = 20;
  localparam int CHROMA_IDX_W = 19;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 11;
  localparam int SIZE_W      = 13;

  localparam logic [CFG_DATA_W-1:0] WIDTH_RESET  = CFG_DATA_W'(352);
  localparam logic [CFG_DATA_W-1:0] HEIGHT_RESET = CFG_DATA_W'(288);

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_CHROMA_MODE  = 2'd0,
    REG_FRAME_WIDTH  = 2'd1,
    REG_FRAME_HEIGHT = 2'd2
  } cfg_reg_t;

  // Clamp a size to [2, maxv] and round it down to even.
  function automatic logic [SIZE_W-1:0] even_clamp(logic [CFG_DATA_W-1:0] v,
                                                   logic [SIZE_W-1:0] maxv);
    logic [SIZE_W-1:0] c;
    c = SIZE_W'(v);
    if (c > maxv) begin
      c = maxv;
    end
    c[0] = 1'b0;
    if (c < SIZE_W'(2)) begin
      c = SIZE_W'(2);
    end
    return c;
  endfunction

endpackage

// ----- hdl/yuyvp_if.sv -----
// Channel interfaces: packed word input, planar result output and register writes.
interface yuyvp_word_if;
  logic                            valid;
  logic                            ready;
  logic [yuyvp_pkg::WORD_W-1:0]    packed_word;

  modport source (output valid, output packed_word, input ready);
  modport sink   (input valid, input packed_word, output ready);
endinterface

interface yuyvp_planar_if;
  logic                                  valid;
  logic                                  ready;
  logic [yuyvp_pkg::LUMA_IDX_W-1:0]      luma_index;
  logic [yuyvp_pkg::BYTE_W-1:0]          luma_first;
  logic [yuyvp_pkg::BYTE_W-1:0]          luma_second;
  logic                                  chroma_write;
  logic [yuyvp_pkg::CHROMA_IDX_W-1:0]    chroma_index;
  logic [yuyvp_pkg::BYTE_W-1:0]          chroma_u;
  logic [yuyvp_pkg::BYTE_W-1:0]          chroma_v;
  logic                                  frame_end;

  modport source (output valid, output luma_index, output luma_first, output luma_second,
                  output chroma_write, output chroma_index, output chroma_u,
                  output chroma_v, output frame_end, input ready);
  modport sink   (input valid, input luma_index, input luma_first, input luma_second,
                  input chroma_write, input chroma_index, input chroma_u,
                  input chroma_v, input frame_end, output ready);
endinterface

interface yuyvp_csr_if;
  logic                               valid;
  logic                               ready;
  logic [yuyvp_pkg::CFG_INDEX_W-1:0]  index;
  logic [yuyvp_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- hdl/yuyvp_cfg.sv -----
// Configuration registers; frame sizes are clamped and stored in counter form when written.
module yuyvp_cfg #(
  parameter int MAX_WIDTH  = yuyvp_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = yuyvp_pkg::MAX_HEIGHT_DEF,
  localparam int PAIR_W    = $clog2(MAX_WIDTH / 2 + 1),
  localparam int ROWS_W    = $clog2(MAX_HEIGHT + 1)
) (
  input  logic              clk,
  input  logic              rst,
  yuyvp_csr_if.sink         csr,
  output logic              chroma_mode,
  output logic [PAIR_W-1:0] pairs,
  output logic [ROWS_W-1:0] rows
);

  localparam logic [yuyvp_pkg::SIZE_W-1:0] WMAX = yuyvp_pkg::SIZE_W'(MAX_WIDTH);
  localparam logic [yuyvp_pkg::SIZE_W-1:0] HMAX = yuyvp_pkg::SIZE_W'(MAX_HEIGHT);

  logic [yuyvp_pkg::SIZE_W-1:0] width_clamped;
  logic [yuyvp_pkg::SIZE_W-1:0] height_clamped;
  logic [yuyvp_pkg::SIZE_W-1:0] width_reset;
  logic [yuyvp_pkg::SIZE_W-1:0] height_reset;

  assign csr.ready = 1'b1;

  assign width_clamped  = yuyvp_pkg::even_clamp(csr.data, WMAX);
  assign height_clamped = yuyvp_pkg::even_clamp(csr.data, HMAX);
  assign width_reset    = yuyvp_pkg::even_clamp(yuyvp_pkg::WIDTH_RESET, WMAX);
  assign height_reset   = yuyvp_pkg::even_clamp(yuyvp_pkg::HEIGHT_RESET, HMAX);

  always_ff @(posedge clk) begin
    if (rst) begin
      chroma_mode <= 1'b0;
      pairs       <= PAIR_W'(width_reset >> 1);
      rows        <= ROWS_W'(height_reset);
    end else if (csr.valid && csr.ready) begin
      unique case (csr.index)
        yuyvp_pkg::REG_CHROMA_MODE:  chroma_mode <= csr.data[0];
        yuyvp_pkg::REG_FRAME_WIDTH:  pairs       <= PAIR_W'(width_clamped >> 1);
        yuyvp_pkg::REG_FRAME_HEIGHT: rows        <= ROWS_W'(height_clamped);
        default: begin
          // Writes beyond the register list are dropped.
        end
      endcase
    end
  end

endmodule

// ----- hdl/yuyv_packed_to_planar.sv -----
// Top level: splits packed YUYV words into luma and chroma plane writes.
//
//  Channel  Role         Beat contents
//  -------  -----------  --------------------------------------------------------
//  yuyv     input        packed_word: Y0, U, Y1, V
//  planar   output       luma index and bytes, chroma write/index/U/V, frame_end
//  csr      config write index (chroma_mode, frame_width, frame_height), data
//
// One word per cycle: each accepted word appears in the output register on the next cycle.
// The only work between registers is the row and frame end compares and the index adders.
// A new word is taken whenever the output register is empty or is being emptied.
// Synchronous reset clears the counters, the output valid and the registers to defaults.
// While the output is stalled, yuyv.ready stays low and the result holds.
module yuyv_packed_to_planar #(
  parameter int MAX_WIDTH  = yuyvp_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = yuyvp_pkg::MAX_HEIGHT_DEF
) (
  input  logic            clk,
  input  logic            rst,
  yuyvp_word_if.sink      yuyv,
  yuyvp_planar_if.source  planar,
  yuyvp_csr_if.sink       csr
);

  localparam int PAIR_W = $clog2(MAX_WIDTH / 2 + 1);
  localparam int ROWS_W = $clog2(MAX_HEIGHT + 1);
  localparam int COL_W  = (MAX_WIDTH / 2 > 1) ? $clog2(MAX_WIDTH / 2) : 1;
  localparam int ROW_W  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int CCMP_W = ((COL_W > PAIR_W) ? COL_W : PAIR_W) + 1;
  localparam int RCMP_W = ((ROW_W > ROWS_W) ? ROW_W : ROWS_W) + 1;

  logic              chroma_mode;
  logic [PAIR_W-1:0] pairs;
  logic [ROWS_W-1:0] rows;

  logic [COL_W-1:0]                      column_pairs;
  logic [ROW_W-1:0]                      row_count;
  logic [yuyvp_pkg::LUMA_IDX_W-1:0]      luma_position;
  logic [yuyvp_pkg::CHROMA_IDX_W-1:0]    chroma_position;

  logic accept;
  logic store_chroma;
  logic row_last;
  logic frame_last;

  yuyvp_cfg #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_cfg (
    .clk         (clk),
    .rst         (rst),
    .csr         (csr),
    .chroma_mode (chroma_mode),
    .pairs       (pairs),
    .rows        (rows)
  );

  assign yuyv.ready = !planar.valid || planar.ready;
  assign accept     = yuyv.valid && yuyv.ready;

  assign store_chroma = !chroma_mode || !row_count[0];
  assign row_last     = (CCMP_W'(column_pairs) + CCMP_W'(1)) >= CCMP_W'(pairs);
  assign frame_last   = row_last && ((RCMP_W'(row_count) + RCMP_W'(1)) >= RCMP_W'(rows));

  // Frame position counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      column_pairs    <= '0;
      row_count       <= '0;
      luma_position   <= '0;
      chroma_position <= '0;
    end else if (accept) begin
      if (frame_last) begin
        column_pairs    <= '0;
        row_count       <= '0;
        luma_position   <= '0;
        chroma_position <= '0;
      end else begin
        luma_position <= luma_position + yuyvp_pkg::LUMA_IDX_W'(2);
        if (store_chroma) begin
          chroma_position <= chroma_position + yuyvp_pkg::CHROMA_IDX_W'(1);
        end
        if (row_last) begin
          column_pairs <= '0;
          row_count    <= row_count + ROW_W'(1);
        end else begin
          column_pairs <= column_pairs + COL_W'(1);
        end
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      planar.valid <= 1'b0;
    end else if (accept) begin
      planar.valid <= 1'b1;
    end else if (planar.ready) begin
      planar.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      planar.luma_index   <= luma_position;
      planar.luma_first   <= yuyv.packed_word[7:0];
      planar.luma_second  <= yuyv.packed_word[23:16];
      planar.chroma_write <= store_chroma;
      planar.chroma_index <= chroma_position;
      planar.chroma_u     <= yuyv.packed_word[15:8];
      planar.chroma_v     <= yuyv.packed_word[31:24];
      planar.frame_end    <= frame_last;
    end
  end

endmodule

// ----- hdl/yuyvp_checker.sv -----
// Port-level assertions for the YUYV splitter, bound to the top level.
module yuyvp_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic [31:0] in_word,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_luma_first,
  input logic [7:0]  out_chroma_v,
  input logic        out_luma_bit0
);

  // A stalled result keeps its valid.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result valid dropped while stalled");

  // Every accepted word gives a result on the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("accepted word produced no result");

  // No new word is taken while a result is held back.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input accepted while output stalled");

  // The result carries the bytes of the word accepted in the previous cycle.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=>
      out_luma_first == $past(in_word[7:0]) && out_chroma_v == $past(in_word[31:24]))
    else $error("result bytes do not match accepted word");

  // Each word covers a pixel pair, so the luma index is always even.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !out_luma_bit0)
    else $error("odd luma index");

endmodule

bind yuyv_packed_to_planar yuyvp_checker u_yuyvp_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (yuyv.valid),
  .in_ready       (yuyv.ready),
  .in_word        (yuyv.packed_word),
  .out_valid      (planar.valid),
  .out_ready      (planar.ready),
  .out_luma_first (planar.luma_first),
  .out_chroma_v   (planar.chroma_v),
  .out_luma_bit0  (planar.luma_index[0])
);

// ----- tb/sv/tb.sv -----
// Self-checking testbench for the packed YUYV to planar splitter.
`timescale 1ns / 1ps

module tb;

  typedef struct {
    logic [yuyvp_pkg::LUMA_IDX_W-1:0]   luma_index;
    logic [yuyvp_pkg::BYTE_W-1:0]       luma_first;
    logic [yuyvp_pkg::BYTE_W-1:0]       luma_second;
    logic                               chroma_write;
    logic [yuyvp_pkg::CHROMA_IDX_W-1:0] chroma_index;
    logic [yuyvp_pkg::BYTE_W-1:0]       chroma_u;
    logic [yuyvp_pkg::BYTE_W-1:0]       chroma_v;
    logic                               frame_end;
  } plane_write_t;

  class plane_write_checker;
    bit                                 keep_even_rows_only;
    int                                 width_reg;
    int                                 height_reg;
    int                                 column;
    int                                 row;
    logic [yuyvp_pkg::LUMA_IDX_W-1:0]   luma_pos;
    logic [yuyvp_pkg::CHROMA_IDX_W-1:0] chroma_pos;
    plane_write_t                       pending_writes[$];
    int                                 errors;
    int                                 shown;

    function new();
      keep_even_rows_only = 1'b0;
      width_reg = 352;
      height_reg = 288;
      column = 0;
      row = 0;
      luma_pos = '0;
      chroma_pos = '0;
      errors = 0;
      shown = 0;
    endfunction

    function int usable_size(int v, int maxv);
      if (v > maxv) begin
        v = maxv;
      end
      v = v & ~1;
      if (v < 2) begin
        v = 2;
      end
      return v;
    endfunction

    function void write_reg(yuyvp_pkg::cfg_reg_t idx,
                            logic [yuyvp_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        yuyvp_pkg::REG_CHROMA_MODE: begin
          keep_even_rows_only = data[0];
        end
        yuyvp_pkg::REG_FRAME_WIDTH: begin
          width_reg = int'(data);
        end
        yuyvp_pkg::REG_FRAME_HEIGHT: begin
          height_reg = int'(data);
        end
        default: begin
        end
      endcase
    endfunction

    function int pending();
      return pending_writes.size();
    endfunction

    // Work out the plane writes for one accepted word and advance the raster position.
    function void note_word(logic [yuyvp_pkg::WORD_W-1:0] w);
      int           pairs;
      int           rows;
      bit           keep_chroma;
      bit           row_last;
      bit           frame_last;
      plane_write_t e;
      pairs = usable_size(width_reg, yuyvp_pkg::MAX_WIDTH_DEF) >> 1;
      rows = usable_size(height_reg, yuyvp_pkg::MAX_HEIGHT_DEF);
      keep_chroma = !keep_even_rows_only || (row % 2 == 0);
      row_last = (column + 1) >= pairs;
      frame_last = row_last && ((row + 1) >= rows);
      e.luma_index = luma_pos;
      e.luma_first = w[7:0];
      e.luma_second = w[23:16];
      e.chroma_write = keep_chroma;
      e.chroma_index = chroma_pos;
      e.chroma_u = w[15:8];
      e.chroma_v = w[31:24];
      e.frame_end = frame_last;
      pending_writes.push_back(e);
      if (frame_last) begin
        column = 0;
        row = 0;
        luma_pos = '0;
        chroma_pos = '0;
      end else begin
        luma_pos = luma_pos + 2'd2;
        if (keep_chroma) begin
          chroma_pos = chroma_pos + 1'b1;
        end
        if (row_last) begin
          column = 0;
          row = row + 1;
        end else begin
          column = column + 1;
        end
      end
    endfunction

    task report(string msg);
      errors++;
      if (shown < 40) begin
        shown++;
        $display("mismatch at %0t: %s", $realtime, msg);
      end
    endtask

    task check_result(plane_write_t got);
      plane_write_t e;
      string        diff;
      if (pending_writes.size() == 0) begin
        report("output beat with no word outstanding");
      end else begin
        e = pending_writes.pop_front();
        diff = "";
        if (got.luma_index !== e.luma_index)
          diff = {diff, $sformatf(" luma_index %0h/%0h", got.luma_index, e.luma_index)};
        if (got.luma_first !== e.luma_first)
          diff = {diff, $sformatf(" luma_first %0h/%0h", got.luma_first, e.luma_first)};
        if (got.luma_second !== e.luma_second)
          diff = {diff, $sformatf(" luma_second %0h/%0h", got.luma_second, e.luma_second)};
        if (got.chroma_write !== e.chroma_write)
          diff = {diff, $sformatf(" chroma_write %0b/%0b", got.chroma_write, e.chroma_write)};
        if (got.chroma_index !== e.chroma_index)
          diff = {diff, $sformatf(" chroma_index %0h/%0h", got.chroma_index, e.chroma_index)};
        if (got.chroma_u !== e.chroma_u)
          diff = {diff, $sformatf(" chroma_u %0h/%0h", got.chroma_u, e.chroma_u)};
        if (got.chroma_v !== e.chroma_v)
          diff = {diff, $sformatf(" chroma_v %0h/%0h", got.chroma_v, e.chroma_v)};
        if (got.frame_end !== e.frame_end)
          diff = {diff, $sformatf(" frame_end %0b/%0b", got.frame_end, e.frame_end)};
        if (diff != "") begin
          report({"got/want:", diff});
        end
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   words_accepted = 0;
  int   words_sent = 0;

  plane_write_checker checker_h = new();

  yuyvp_word_if   word_ch();
  yuyvp_planar_if planar_ch();
  yuyvp_csr_if    csr_ch();

  yuyv_packed_to_planar uut (
    .clk    (clk),
    .rst    (rst),
    .yuyv   (word_ch),
    .planar (planar_ch),
    .csr    (csr_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // No random idles in this window, though the receiver's long hold-off falls in it.
  wire calm = (words_accepted >= 150) && (words_accepted < 320);

  // Output beats are checked before the word taken at the same edge is noted.
  always @(posedge clk) begin
    plane_write_t got;
    if (!rst) begin
      if (planar_ch.valid && planar_ch.ready) begin
        got.luma_index = planar_ch.luma_index;
        got.luma_first = planar_ch.luma_first;
        got.luma_second = planar_ch.luma_second;
        got.chroma_write = planar_ch.chroma_write;
        got.chroma_index = planar_ch.chroma_index;
        got.chroma_u = planar_ch.chroma_u;
        got.chroma_v = planar_ch.chroma_v;
        got.frame_end = planar_ch.frame_end;
        checker_h.check_result(got);
      end
      if (word_ch.valid && word_ch.ready) begin
        checker_h.note_word(word_ch.packed_word);
        words_accepted++;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off while words keep coming.
  initial begin
    int hold_left;
    bit held;
    hold_left = 0;
    held = 1'b0;
    planar_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        planar_ch.ready <= 1'b0;
      end else if (!held && words_accepted >= 200) begin
        held = 1'b1;
        hold_left = 60;
        planar_ch.ready <= 1'b0;
      end else begin
        planar_ch.ready <= calm || ($urandom_range(0, 99) >= 33);
      end
    end
  end

  task automatic send_word(input logic [yuyvp_pkg::WORD_W-1:0] w);
    while (!calm && $urandom_range(0, 99) < 33) begin
      word_ch.valid <= 1'b0;
      @(posedge clk);
    end
    word_ch.valid <= 1'b1;
    word_ch.packed_word <= w;
    do @(posedge clk); while (!(word_ch.valid && word_ch.ready));
    words_sent++;
  endtask

  task automatic send_random(input int n);
    repeat (n) send_word($urandom);
    word_ch.valid <= 1'b0;
  endtask

  // Writes the selected registers back to back; valid stays high between them.
  task automatic program_regs(input bit [2:0] sel,
                              input logic [yuyvp_pkg::CFG_DATA_W-1:0] mode_v,
                              input logic [yuyvp_pkg::CFG_DATA_W-1:0] width_v,
                              input logic [yuyvp_pkg::CFG_DATA_W-1:0] height_v);
    logic [yuyvp_pkg::CFG_DATA_W-1:0] vals[3];
    vals[0] = mode_v;
    vals[1] = width_v;
    vals[2] = height_v;
    for (int i = 0; i < 3; i++) begin
      if (sel[i]) begin
        csr_ch.valid <= 1'b1;
        csr_ch.index <= yuyvp_pkg::cfg_reg_t'(i);
        csr_ch.data <= vals[i];
        do @(posedge clk); while (!csr_ch.ready);
        checker_h.write_reg(yuyvp_pkg::cfg_reg_t'(i), vals[i]);
      end
    end
    csr_ch.valid <= 1'b0;
  endtask

  // The last word is noted at its accepting edge, so step past that edge before
  // looking at the outstanding count; spare cycles follow.
  task automatic drain();
    @(posedge clk);
    while (checker_h.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    logic [yuyvp_pkg::WORD_W-1:0]     corner_words[6];
    logic [yuyvp_pkg::CFG_DATA_W-1:0] w_v;
    logic [yuyvp_pkg::CFG_DATA_W-1:0] h_v;
    corner_words = '{32'h0000_0000, 32'hffff_ffff, 32'h0102_0304,
                     32'hff00_ff00, 32'h00ff_00ff, 32'haaaa_5555};
    word_ch.valid <= 1'b0;
    word_ch.packed_word <= '0;
    csr_ch.valid <= 1'b0;
    csr_ch.index <= yuyvp_pkg::REG_CHROMA_MODE;
    csr_ch.data <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Reset sizes first, then the corner cases of the size registers.
    foreach (corner_words[i]) send_word(corner_words[i]);
    word_ch.valid <= 1'b0;
    drain();
    program_regs(3'b111, 11'd1, 11'd2, 11'd2);
    send_random(5);
    drain();
    // Too small and odd: both sizes become two.
    program_regs(3'b111, 11'd0, 11'd0, 11'd1);
    send_random(3);
    drain();
    // Widest row, then shrink the row while far past its new end.
    program_regs(3'b111, 11'h7fe, 11'h7ff, 11'd2);
    send_random(4);
    drain();
    program_regs(3'b111, 11'd1, 11'd5, 11'd7);
    send_random(4);
    drain();
    // Tallest frame, then cut the height below the current row.
    program_regs(3'b110, 11'd0, 11'd6, 11'h7ff);
    send_random(7);
    drain();
    program_regs(3'b101, 11'd0, 11'd6, 11'd3);
    send_random(3);
    drain();

    while (words_sent < 550) begin
      w_v = ($urandom_range(0, 7) == 0) ? 11'($urandom_range(0, 2047))
                                        : 11'($urandom_range(0, 20));
      h_v = ($urandom_range(0, 7) == 0) ? 11'($urandom_range(0, 2047))
                                        : 11'($urandom_range(0, 12));
      program_regs(3'($urandom_range(1, 7)), 11'($urandom), w_v, h_v);
      send_random($urandom_range(4, 50));
      drain();
    end

    if (checker_h.errors == 0 && checker_h.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
